[design/pat_pkg.sv]
// Shared types, constants and the arctangent table for the point affine transform.
// No dependencies; every other design file imports this package.
package pat_pkg;

    localparam int COORD_W       = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 12;
    localparam int FACTOR_W      = 16;
    localparam int ANGLE_W       = 16;
    localparam int FACTOR_FRAC   = 12;

    // point minus center, then with guard bits and CORDIC growth headroom
    localparam int D_W      = COORD_W + 1;
    localparam int XY_W     = D_W + GUARD_BITS + 3;
    localparam int Z_W      = ANGLE_W + 16;
    localparam int GAIN_W   = 31;
    localparam int PROD_W   = XY_W + GAIN_W;
    localparam int RES_W    = COORD_W + 6;
    localparam int ROT_SHIFT = 30 + GUARD_BITS;
    localparam int STG_IDX_W = 5;
    localparam int NUM_PIPE  = CORDIC_STAGES + 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = (COORD_W > 16) ? COORD_W : 16;
    localparam int TDATA_IN_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 * COORD_W + 7) / 8) * 8;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    localparam logic signed [PROD_W-1:0] ROT_HALF =
        {{(PROD_W - ROT_SHIFT){1'b0}}, 1'b1, {(ROT_SHIFT - 1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SCALE_HALF =
        {{(PROD_W - FACTOR_FRAC){1'b0}}, 1'b1, {(FACTOR_FRAC - 1){1'b0}}};

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd16384;
    localparam logic signed [FACTOR_W-1:0] FACTOR_ONE  = 16'sd4096;

    typedef enum logic [1:0] {
        MODE_TRANSLATE,
        MODE_ROTATE,
        MODE_SCALE,
        MODE_PASS
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_FACTOR_X,
        REG_FACTOR_Y,
        REG_ANGLE
    } t_reg_idx;

    typedef struct packed {
        t_mode                       mode;
        logic signed [COORD_W-1:0]   center_x;
        logic signed [COORD_W-1:0]   center_y;
        logic signed [COORD_W-1:0]   offset_x;
        logic signed [COORD_W-1:0]   offset_y;
        logic signed [FACTOR_W-1:0]  factor_x;
        logic signed [FACTOR_W-1:0]  factor_y;
        logic signed [ANGLE_W-1:0]   angle;
    } t_cfg;

    // payload carried down the CORDIC pipe; raw point rides along for the other modes
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
    } t_cord;

    // atan(2^-i) in a 32-bit binary angle
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STG_IDX_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            5'd20:   r = 32'sd652;
            5'd21:   r = 32'sd326;
            5'd22:   r = 32'sd163;
            5'd23:   r = 32'sd81;
            5'd24:   r = 32'sd41;
            5'd25:   r = 32'sd20;
            5'd26:   r = 32'sd10;
            5'd27:   r = 32'sd5;
            5'd28:   r = 32'sd3;
            5'd29:   r = 32'sd1;
            5'd30:   r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

[design/pat_entry.sv]
// Entry stage: point minus center with guard bits, quarter-turn pre-rotation, angle setup.
// Depends on pat_pkg.
module pat_entry (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic signed [pat_pkg::COORD_W-1:0] i_px,
    input  logic signed [pat_pkg::COORD_W-1:0] i_py,
    input  pat_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output pat_pkg::t_cord                o_data
);
    import pat_pkg::*;

    logic                      r_valid;
    t_cord                     r_data;
    t_cord                     n_data;
    logic signed [D_W-1:0]     w_dx;
    logic signed [D_W-1:0]     w_dy;
    logic signed [XY_W-1:0]    w_gx;
    logic signed [XY_W-1:0]    w_gy;
    logic signed [ANGLE_W-1:0] w_ang;

    assign w_dx = D_W'(i_px) - D_W'(i_cfg.center_x);
    assign w_dy = D_W'(i_py) - D_W'(i_cfg.center_y);
    assign w_gx = XY_W'(w_dx) <<< GUARD_BITS;
    assign w_gy = XY_W'(w_dy) <<< GUARD_BITS;

    always_comb begin
        n_data.px = i_px;
        n_data.py = i_py;
        if (i_cfg.angle > QUARTER_TURN) begin
            // turn +90 first
            n_data.x = -w_gy;
            n_data.y = w_gx;
            w_ang    = i_cfg.angle - QUARTER_TURN;
        end else if (i_cfg.angle < -QUARTER_TURN) begin
            // turn -90 first
            n_data.x = w_gy;
            n_data.y = -w_gx;
            w_ang    = i_cfg.angle + QUARTER_TURN;
        end else begin
            n_data.x = w_gx;
            n_data.y = w_gy;
            w_ang    = i_cfg.angle;
        end
        n_data.z = {w_ang, {(Z_W - ANGLE_W){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/pat_cordic_stage.sv]
// One rotation-mode CORDIC iteration with its pipeline register.
// Depends on pat_pkg (payload type and arctangent table).
module pat_cordic_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic [pat_pkg::STG_IDX_W-1:0]     i_stage,
    input  pat_pkg::t_cord                    i_data,
    output logic                              o_valid,
    output pat_pkg::t_cord                    o_data
);
    import pat_pkg::*;

    logic                   r_valid;
    t_cord                  r_data;
    t_cord                  n_data;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_at;

    assign w_xs = i_data.x >>> i_stage;
    assign w_ys = i_data.y >>> i_stage;
    assign w_at = atan_lut(i_stage);

    always_comb begin
        n_data.px = i_data.px;
        n_data.py = i_data.py;
        if (!i_data.z[Z_W-1]) begin
            // counterclockwise step
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - w_at;
        end else begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/pat_post.sv]
// Back end: gain/scale multiply or offset add (one stage), then round, recenter and saturate.
// Depends on pat_pkg.
module pat_post (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv_m,
    input  logic                               i_adv_f,
    input  logic                               i_valid,
    input  pat_pkg::t_cord                     i_data,
    input  pat_pkg::t_cfg                      i_cfg,
    output logic                               o_valid_m,
    output logic                               o_valid,
    output logic signed [pat_pkg::COORD_W-1:0] o_x,
    output logic signed [pat_pkg::COORD_W-1:0] o_y,
    output logic                               o_clip
);
    import pat_pkg::*;

    logic                      r_valid_m;
    logic signed [PROD_W-1:0]  r_prod_x;
    logic signed [PROD_W-1:0]  r_prod_y;
    logic signed [PROD_W-1:0]  n_prod_x;
    logic signed [PROD_W-1:0]  n_prod_y;
    logic signed [D_W-1:0]     w_dx;
    logic signed [D_W-1:0]     w_dy;
    logic                      r_valid;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic                      r_clip;
    logic [COORD_W:0]          w_fx;
    logic [COORD_W:0]          w_fy;

    // returns {clip, value}
    function automatic logic [COORD_W:0] finish(input logic signed [PROD_W-1:0] p,
                                                input logic signed [COORD_W-1:0] c,
                                                input t_mode m);
        logic signed [PROD_W-1:0] sh;
        logic signed [RES_W-1:0]  v;
        logic [COORD_W:0]         r;
        sh = p;
        case (m)
            MODE_ROTATE: begin
                sh = (p + ROT_HALF) >>> ROT_SHIFT;
                v  = RES_W'(sh) + RES_W'(c);
            end
            MODE_SCALE: begin
                sh = (p + SCALE_HALF) >>> FACTOR_FRAC;
                v  = RES_W'(sh) + RES_W'(c);
            end
            default: begin
                v = RES_W'(sh);
            end
        endcase
        if (v > RES_W'(COORD_MAX)) begin
            r = {1'b1, COORD_MAX};
        end else if (v < RES_W'(COORD_MIN)) begin
            r = {1'b1, COORD_MIN};
        end else begin
            r = {1'b0, v[COORD_W-1:0]};
        end
        return r;
    endfunction

    assign w_dx = D_W'(i_data.px) - D_W'(i_cfg.center_x);
    assign w_dy = D_W'(i_data.py) - D_W'(i_cfg.center_y);

    always_comb begin
        case (i_cfg.mode)
            MODE_TRANSLATE: begin
                n_prod_x = PROD_W'(i_data.px) + PROD_W'(i_cfg.offset_x);
                n_prod_y = PROD_W'(i_data.py) + PROD_W'(i_cfg.offset_y);
            end
            MODE_ROTATE: begin
                n_prod_x = i_data.x * GAIN_Q30;
                n_prod_y = i_data.y * GAIN_Q30;
            end
            MODE_SCALE: begin
                n_prod_x = w_dx * i_cfg.factor_x;
                n_prod_y = w_dy * i_cfg.factor_y;
            end
            default: begin
                n_prod_x = PROD_W'(i_data.px);
                n_prod_y = PROD_W'(i_data.py);
            end
        endcase
    end

    assign w_fx = finish(r_prod_x, i_cfg.center_x, i_cfg.mode);
    assign w_fy = finish(r_prod_y, i_cfg.center_y, i_cfg.mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_adv_m) begin
                r_valid_m <= i_valid;
            end
            if (i_adv_f) begin
                r_valid <= r_valid_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_m && i_valid) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
        if (i_adv_f && r_valid_m) begin
            r_x    <= w_fx[COORD_W-1:0];
            r_y    <= w_fy[COORD_W-1:0];
            r_clip <= w_fx[COORD_W] | w_fy[COORD_W];
        end
    end

    assign o_valid_m = r_valid_m;
    assign o_valid   = r_valid;
    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_clip    = r_clip;

endmodule

[design/point_affine_transform_top.sv]
// Top level of the 2D point transform: config registers, pipeline control, stage chain.
// Depends on pat_pkg, pat_entry, pat_cordic_stage and pat_post.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------------------
//  s (in)    in         i_s_tvalid/o_s_tready   tdata: x_in [15:0], y_in [31:16]
//  m (out)   out        o_m_tvalid/i_m_tready   tdata: x_out [15:0], y_out [31:16];
//                                               tuser: clipped
//  cfg       in         i_cfg_valid/o_cfg_ready index 0..7, data (register value)
//
// One point per cycle while the output does not stall the pipe; the stages are the entry
// stage, one stage per CORDIC iteration, the multiply stage and the round/saturate stage
// that is the output register. The CORDIC iteration chain sets the depth.
// Reset (synchronous, active low) empties the pipe and returns the registers to their
// defaults: translate mode, zero center/offset/angle, factors 1.0.
// A stall on the output only holds stages that are full all the way to the end; bubbles
// in front keep filling, so while a result waits the input takes transfers until none is left.
// Config writes are taken every cycle; write them only while the pipe is empty.
module point_affine_transform_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream; tdata: x_in, y_in
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [pat_pkg::TDATA_IN_W-1:0]       i_s_tdata,
    // output stream; tdata: x_out, y_out; tuser: clipped
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [pat_pkg::TDATA_OUT_W-1:0]      o_m_tdata,
    output logic                                 o_m_tuser,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pat_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pat_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import pat_pkg::*;

    t_cfg                      r_cfg;
    logic [NUM_PIPE-1:0]       w_valid;
    logic [NUM_PIPE-1:0]       w_ready;
    t_cord                     w_cord [0:CORDIC_STAGES];
    logic signed [COORD_W-1:0] w_x;
    logic signed [COORD_W-1:0] w_y;

    // ---------------------------------------------------------------- config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= MODE_TRANSLATE;
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.factor_x <= FACTOR_ONE;
            r_cfg.factor_y <= FACTOR_ONE;
            r_cfg.angle    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MODE:     r_cfg.mode     <= t_mode'(i_cfg_data[1:0]);
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data[COORD_W-1:0];
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data[COORD_W-1:0];
                REG_OFFSET_X: r_cfg.offset_x <= i_cfg_data[COORD_W-1:0];
                REG_OFFSET_Y: r_cfg.offset_y <= i_cfg_data[COORD_W-1:0];
                REG_FACTOR_X: r_cfg.factor_x <= i_cfg_data[FACTOR_W-1:0];
                REG_FACTOR_Y: r_cfg.factor_y <= i_cfg_data[FACTOR_W-1:0];
                REG_ANGLE:    r_cfg.angle    <= i_cfg_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- pipeline control
    // Stage k may load when the output drains or some stage at or after k is empty.
    always_comb begin
        logic [NUM_PIPE-1:0] low_mask;
        low_mask = '0;
        for (int k = 0; k < NUM_PIPE; k++) begin
            w_ready[k]  = i_m_tready | ~(&(w_valid | low_mask));
            low_mask[k] = 1'b1;
        end
    end

    assign o_s_tready = w_ready[0];

    // ---------------------------------------------------------------- datapath
    pat_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_ready[0]),
        .i_valid (i_s_tvalid),
        .i_px    (i_s_tdata[COORD_W-1:0]),
        .i_py    (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_cfg   (r_cfg),
        .o_valid (w_valid[0]),
        .o_data  (w_cord[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        pat_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_ready[g+1]),
            .i_valid (w_valid[g]),
            .i_stage (STG_IDX_W'(g)),
            .i_data  (w_cord[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_cord[g+1])
        );
    end

    pat_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv_m   (w_ready[CORDIC_STAGES+1]),
        .i_adv_f   (w_ready[CORDIC_STAGES+2]),
        .i_valid   (w_valid[CORDIC_STAGES]),
        .i_data    (w_cord[CORDIC_STAGES]),
        .i_cfg     (r_cfg),
        .o_valid_m (w_valid[CORDIC_STAGES+1]),
        .o_valid   (w_valid[CORDIC_STAGES+2]),
        .o_x       (w_x),
        .o_y       (w_y),
        .o_clip    (o_m_tuser)
    );

    assign o_m_tvalid = w_valid[CORDIC_STAGES+2];
    assign o_m_tdata  = TDATA_OUT_W'({w_y, w_x});

endmodule

[design/pat_checker.sv]
// Port-level checks on the point transform, bound to the top level.
// Depends on pat_pkg and point_affine_transform_top.
module pat_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [pat_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    input logic                               o_m_tuser
);
    import pat_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output changed while stalled");

    // with nothing at the output the pipe cannot be full
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input refused while output empty");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("result present right after reset");

    // clipped only on a coordinate pinned at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata[COORD_W-1:0] == COORD_MAX) || (o_m_tdata[COORD_W-1:0] == COORD_MIN) ||
            (o_m_tdata[2*COORD_W-1:COORD_W] == COORD_MAX) ||
            (o_m_tdata[2*COORD_W-1:COORD_W] == COORD_MIN))
        else $error("clipped set without a saturated coordinate");

endmodule

bind point_affine_transform_top pat_checker u_pat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for point_affine_transform_top: a directed table, then random phases.
// Depends on pat_pkg and the design files; a local predictor supplies all but the known points.
module tb_top;
    import pat_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_LEN   = 125;
    localparam int MAX_REPORTS = 10;

    // Q0.30 CORDIC gain compensation; result drops 12 guard and 30 gain bits
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam int     GUARD_SCALE = 4096;
    localparam int     DROP_BITS   = 42;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      clip;
    } t_point_res;

    typedef enum logic {ROW_WRITE, ROW_POINT} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        t_reg_idx                  idx;
        logic [15:0]               val;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        bit                        typed;
        t_point_res                res;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [TDATA_IN_W-1:0]     i_s_tdata = '0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]    o_m_tdata;
    logic                      o_m_tuser;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    point_affine_transform_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // atan(2^-i) as a 32-bit binary angle, indexed by CORDIC iteration
    longint atan_bam [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    t_cfg        xf_cfg;            // register values as the block holds them
    t_point_res  pending_points[$]; // transformed points still owed by the block
    t_plan_row   plan[$];           // directed stimulus table

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int bad_results   = 0;
    int results_seen  = 0;
    int clipped_seen  = 0;
    int points_sent   = 0;
    int reg_writes    = 0;
    int mode_hits [4] = '{0, 0, 0, 0};

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Saturate a wide result to the coordinate range.
    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic bit out_of_range(input longint v);
        return (v > 32767) || (v < -32768);
    endfunction

    // Transform one point under the current register values.
    function automatic t_point_res transform_point(input logic signed [COORD_W-1:0] px,
                                                   input logic signed [COORD_W-1:0] py);
        longint     cx, cy, rx, ry, x, y, z, a, t, xs, ys;
        t_point_res r;
        cx = longint'(xf_cfg.center_x);
        cy = longint'(xf_cfg.center_y);
        rx = longint'(px);
        ry = longint'(py);
        case (xf_cfg.mode)
            MODE_TRANSLATE: begin
                rx = longint'(px) + longint'(xf_cfg.offset_x);
                ry = longint'(py) + longint'(xf_cfg.offset_y);
            end
            MODE_ROTATE: begin
                x = (longint'(px) - cx) * GUARD_SCALE;
                y = (longint'(py) - cy) * GUARD_SCALE;
                a = longint'(xf_cfg.angle);
                // beyond a quarter turn: pre-rotate by exactly 90 degrees
                if (a > 16384) begin
                    t = x; x = -y; y = t; a = a - 16384;
                end else if (a < -16384) begin
                    t = x; x = y; y = -t; a = a + 16384;
                end
                z = a * 65536;
                for (int i = 0; i < CORDIC_STAGES; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0) begin
                        x = x - ys; y = y + xs; z = z - atan_bam[i % 32];
                    end else begin
                        x = x + ys; y = y - xs; z = z + atan_bam[i % 32];
                    end
                end
                rx = ((x * CORDIC_GAIN + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS) + cx;
                ry = ((y * CORDIC_GAIN + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS) + cy;
            end
            MODE_SCALE: begin
                rx = (((longint'(px) - cx) * longint'(xf_cfg.factor_x) + 2048) >>> 12) + cx;
                ry = (((longint'(py) - cy) * longint'(xf_cfg.factor_y) + 2048) >>> 12) + cy;
            end
            default: ;
        endcase
        r.x    = clamp_coord(rx);
        r.y    = clamp_coord(ry);
        r.clip = out_of_range(rx) || out_of_range(ry);
        return r;
    endfunction

    function automatic void add_write(input t_reg_idx idx, input logic [15:0] val);
        t_plan_row r;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.val   = val;
        r.px    = '0;
        r.py    = '0;
        r.typed = 1'b0;
        r.res   = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_point(input logic signed [COORD_W-1:0] px,
                                      input logic signed [COORD_W-1:0] py);
        t_plan_row r;
        r.kind  = ROW_POINT;
        r.idx   = REG_MODE;
        r.val   = '0;
        r.px    = px;
        r.py    = py;
        r.typed = 1'b0;
        r.res   = '0;
        plan.push_back(r);
    endfunction

    // Point whose result is known by inspection; the predictor is bypassed.
    function automatic void add_known(input logic signed [COORD_W-1:0] px,
                                      input logic signed [COORD_W-1:0] py,
                                      input logic signed [COORD_W-1:0] ex,
                                      input logic signed [COORD_W-1:0] ey,
                                      input logic ec);
        add_point(px, py);
        plan[$].typed    = 1'b1;
        plan[$].res.x    = ex;
        plan[$].res.y    = ey;
        plan[$].res.clip = ec;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(2047)) - 1024);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_factor();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h1000;
            3:       return 16'hF000;
            4:       return 16'h0000;
            5, 6:    return 16'(int'($urandom_range(16384)) - 8192);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h4000;
            3:       return 16'hC000;
            4:       return 16'h4001;
            5:       return 16'hBFFF;
            6:       return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_point_coord();
        case ($urandom_range(15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'(int'($urandom_range(2047)) - 1024);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Write one register; valid stays up so a following write can reuse the cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:     xf_cfg.mode     = t_mode'(val[1:0]);
            REG_CENTER_X: xf_cfg.center_x = val;
            REG_CENTER_Y: xf_cfg.center_y = val;
            REG_OFFSET_X: xf_cfg.offset_x = val;
            REG_OFFSET_Y: xf_cfg.offset_y = val;
            REG_FACTOR_X: xf_cfg.factor_x = val;
            REG_FACTOR_Y: xf_cfg.factor_y = val;
            REG_ANGLE:    xf_cfg.angle    = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Present one point after a random idle gap and hold it until the transfer.
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_tready);
        mode_hits[xf_cfg.mode]++;
        points_sent++;
    endtask

    // Drop valid and hold until every owed point has come back.
    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: stall at random with the current percentage.
    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each output transfer with the oldest owed point.
    always @(posedge i_clk) begin : result_check
        t_point_res got;
        t_point_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x    = o_m_tdata[COORD_W-1:0];
            got.y    = o_m_tdata[2*COORD_W-1:COORD_W];
            got.clip = o_m_tuser;
            results_seen++;
            if (got.clip)
                clipped_seen++;
            if (pending_points.size() == 0) begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d clip=%0b",
                             $time, got.x, got.y, got.clip);
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.clip !== want.clip) begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("%0t: mismatch expected x=%0d y=%0d clip=%0b, got x=%0d y=%0d clip=%0b",
                                 $time, want.x, want.y, want.clip, got.x, got.y, got.clip);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points still owed",
                     cycle_count, pending_points.size());
            $display("point_affine_transform_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row        row;
        bit               after_point;
        t_mode            phase_mode;
        logic signed [COORD_W-1:0] px, py;

        xf_cfg.mode     = MODE_TRANSLATE;
        xf_cfg.center_x = '0;
        xf_cfg.center_y = '0;
        xf_cfg.offset_x = '0;
        xf_cfg.offset_y = '0;
        xf_cfg.factor_x = FACTOR_ONE;
        xf_cfg.factor_y = FACTOR_ONE;
        xf_cfg.angle    = '0;

        // Directed table: reset defaults first, then saturation, mirror, factor
        // extremes, center extremes, every angle region, and the pass-through mode.
        add_known(0, 0, 0, 0, 1'b0);
        add_known(32767, -32768, 32767, -32768, 1'b0);
        add_known(-1, 1, -1, 1, 1'b0);
        add_write(REG_OFFSET_X, 16'h0001);
        add_write(REG_OFFSET_Y, 16'hFFFF);
        add_known(32767, -32768, 32767, -32768, 1'b1);
        add_known(5, 5, 6, 4, 1'b0);
        add_write(REG_OFFSET_X, 16'h8000);
        add_write(REG_OFFSET_Y, 16'h7FFF);
        add_known(-32768, 32767, -32768, 32767, 1'b1);
        add_known(32767, -32768, -1, -1, 1'b0);
        add_write(REG_MODE, 16'(MODE_SCALE));
        add_write(REG_FACTOR_X, 16'hF000);
        add_known(-32768, 100, 32767, 100, 1'b1);
        add_known(1000, -1000, -1000, -1000, 1'b0);
        add_write(REG_FACTOR_X, 16'h7FFF);
        add_write(REG_FACTOR_Y, 16'h8000);
        add_known(16384, -16384, 32767, 32767, 1'b1);
        add_known(0, 0, 0, 0, 1'b0);
        add_write(REG_CENTER_X, 16'h7FFF);
        add_write(REG_CENTER_Y, 16'h8000);
        add_point(-32768, 32767);
        add_known(32767, -32768, 32767, -32768, 1'b0);
        add_write(REG_MODE, 16'(MODE_ROTATE));
        add_point(-32768, 32767);
        add_point(1234, -5678);
        add_write(REG_CENTER_X, 16'h0000);
        add_write(REG_CENTER_Y, 16'h0000);
        add_write(REG_ANGLE, 16'h4000);
        add_point(16384, 0);
        add_write(REG_ANGLE, 16'h4001);
        add_point(16384, -8192);
        add_write(REG_ANGLE, 16'h7FFF);
        add_point(32767, 32767);
        add_write(REG_ANGLE, 16'h8000);
        add_point(-32768, -32768);
        add_write(REG_ANGLE, 16'hC000);
        add_point(0, 16384);
        add_write(REG_ANGLE, 16'hBFFF);
        add_point(-20000, 12345);
        add_write(REG_MODE, 16'(MODE_PASS));
        add_known(32767, -32768, 32767, -32768, 1'b0);
        add_known(-1, 0, -1, 0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; drain before any write that follows a point.
        after_point = 1'b0;
        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_WRITE) begin
                if (after_point)
                    drain_pipe();
                after_point = 1'b0;
                write_reg(row.idx, row.val);
            end else begin
                after_point = 1'b1;
                send_point(row.px, row.py);
                pending_points.push_back(row.typed ? row.res : transform_point(row.px, row.py));
            end
        end

        // Random phases: each rotates the idle profile and the mode and redraws registers at random.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipe();
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 78; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            phase_mode = t_mode'((phase + phase / 4) % 4);
            write_reg(REG_MODE, 16'(phase_mode));
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_CENTER_X, pick_coord());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_CENTER_Y, pick_coord());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_OFFSET_X, pick_coord());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_OFFSET_Y, pick_coord());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_FACTOR_X, pick_factor());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_FACTOR_Y, pick_factor());
            if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_ANGLE, pick_angle());
            for (int n = 0; n < PHASE_LEN; n++) begin
                // hold the sender once mid-phase until the pipe is empty
                if (phase == 5 && n == PHASE_LEN / 2)
                    drain_pipe();
                px = pick_point_coord();
                py = pick_point_coord();
                send_point(px, py);
                pending_points.push_back(transform_point(px, py));
            end
        end

        drain_pipe();
        stall_pct = 0;
        repeat (2 * NUM_PIPE) @(posedge i_clk);

        $display("covered %0d points (translate %0d, rotate %0d, scale %0d, pass %0d), %0d register writes",
                 points_sent, mode_hits[MODE_TRANSLATE], mode_hits[MODE_ROTATE],
                 mode_hits[MODE_SCALE], mode_hits[MODE_PASS], reg_writes);
        $display("checked %0d results, %0d clipped, %0d bad, %0d still owed",
                 results_seen, clipped_seen, bad_results, pending_points.size());
        if (bad_results == 0 && pending_points.size() == 0)
            $display("point_affine_transform_top regression: pass");
        else
            $display("point_affine_transform_top regression: fail");
        $finish;
    end

endmodule

[filelist.f]
design/pat_pkg.sv
design/pat_entry.sv
design/pat_cordic_stage.sv
design/pat_post.sv
design/point_affine_transform_top.sv
design/pat_checker.sv
tb/tb_top.sv
